### src/spqt_pkg.sv
package spqt_pkg;

  // Default build parameters
  localparam int CANVAS_CENTRE_DEF   = 512;
  localparam int SCALE_FRAC_BITS_DEF = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 6;

  // Datapath widths: coordinates are Q.8 held within +-2^40
  localparam int CW  = 42;
  localparam int AW  = 43;
  localparam int BW  = 16;
  localparam int PW  = AW + BW;
  localparam int TLW = 25;

  // Trig result format and rotation rounding
  localparam int TRIG_FRAC = 14;
  localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_OFF_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_OFF_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SCALE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SCALE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ARR_OFF_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARR_OFF_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ARR_SCALE_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ARR_SCALE_Y = 3'd7;

  localparam logic signed [15:0] UNITY_SCALE = 16'sd4096;

  // Queue between front and back
  localparam int QDEPTH = 2;

  localparam logic signed [63:0] LIM40_64 = 64'sd1 <<< 40;
  localparam logic signed [63:0] MAX32_64 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32_64 = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] obj_off_x;
    logic signed [15:0] obj_off_y;
    logic signed [15:0] obj_scale_x;
    logic signed [15:0] obj_scale_y;
    logic signed [15:0] arr_off_x;
    logic signed [15:0] arr_off_y;
    logic signed [15:0] arr_scale_x;
    logic signed [15:0] arr_scale_y;
  } cfg_t;

  typedef struct packed {
    logic                   is_part;
    logic signed [15:0]     pos_x;
    logic signed [15:0]     pos_y;
    logic signed [15:0]     scale_x;
    logic signed [15:0]     scale_y;
    logic signed [16:0]     angle;
    logic [11:0]            region_w;
    logic [11:0]            region_h;
    logic                   flip_x;
    logic                   flip_y;
    logic signed [TLW-1:0]  tl_x;
    logic signed [TLW-1:0]  tl_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic               skip;
  } trig_t;

  // Arctangent of 2^-i in Q.16 degrees
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    return 22'd2949120;
      4'd1:    return 22'd1740967;
      4'd2:    return 22'd919879;
      4'd3:    return 22'd466945;
      4'd4:    return 22'd234379;
      4'd5:    return 22'd117304;
      4'd6:    return 22'd58666;
      4'd7:    return 22'd29335;
      4'd8:    return 22'd14668;
      4'd9:    return 22'd7334;
      4'd10:   return 22'd3667;
      4'd11:   return 22'd1833;
      4'd12:   return 22'd917;
      4'd13:   return 22'd458;
      4'd14:   return 22'd229;
      default: return 22'd115;
    endcase
  endfunction

  // Shift right by n with round half up
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                               input int unsigned n);
    logic signed [63:0] half;
    half = (n == 0) ? 64'sd0 : (64'sd1 <<< (n - 1));
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [CW-1:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > LIM40_64) t = LIM40_64;
    if (v < -LIM40_64) t = -LIM40_64;
    return t[CW-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > MAX32_64) t = MAX32_64;
    if (v < MIN32_64) t = MIN32_64;
    return t[31:0];
  endfunction

endpackage

### src/spqt_ifs.sv
interface spqt_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] angle;
  logic [11:0]        region_w;
  logic [11:0]        region_h;
  logic               flip_x;
  logic               flip_y;

  modport source (output valid, mode, pos_x, pos_y, scale_x, scale_y, angle,
                  region_w, region_h, flip_x, flip_y, input ready);
  modport sink (input valid, mode, pos_x, pos_y, scale_x, scale_y, angle,
                region_w, region_h, flip_x, flip_y, output ready);
endinterface

interface spqt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic               last;

  modport source (output valid, corner, vert_x, vert_y, last, input ready);
  modport sink (input valid, corner, vert_x, vert_y, last, output ready);
endinterface

### src/sprite_part_quad_transform.sv
// Key items are taken by the back end straight from its idle state; they
// latch the key transform and give no result. For a part item, the shared
// sine/cosine unit runs first for the part angle and then for the key angle,
// and then the four-multiplier datapath scales and arranges the rectangle and
// transforms each vertex in turn. A two-entry queue lets input items be taken
// while a part is in work. Reset is synchronous, active low.
module sprite_part_quad_transform #(
  parameter int CANVAS_CENTRE   = spqt_pkg::CANVAS_CENTRE_DEF,
  parameter int SCALE_FRAC_BITS = spqt_pkg::SCALE_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = spqt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spqt_in_if.sink                        in_item,
  spqt_out_if.source                     out_item,
  input  logic                           cfg_we,
  input  logic [spqt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                    cfg_wdata
);
  import spqt_pkg::*;

  cfg_t               cfg;
  item_t              push_data, pop_data;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic               trig_start, trig_done;
  logic signed [16:0] trig_angle;
  trig_t              trig_res;

  // Front end: configuration and item classification
  spqt_front #(.CANVAS_CENTRE(CANVAS_CENTRE)) u_front (
    .clk, .rst_n, .in_item, .cfg_we, .cfg_idx, .cfg_wdata, .cfg,
    .push_valid, .push_data, .push_ready
  );

  // Queue between front and back
  spqt_queue u_queue (
    .clk, .rst_n, .push_valid, .push_data, .push_ready,
    .pop_valid, .pop_data, .pop_ready
  );

  // Shared sine/cosine unit
  spqt_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig (
    .clk, .rst_n, .start(trig_start), .angle(trig_angle),
    .done(trig_done), .res(trig_res)
  );

  // Back end: transform sequencer and output register
  spqt_back #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_back (
    .clk, .rst_n, .pop_valid, .pop_data, .pop_ready, .cfg,
    .trig_start, .trig_angle, .trig_done, .trig_res, .out_item
  );

endmodule

### src/spqt_front.sv
module spqt_front #(
  parameter int CANVAS_CENTRE = spqt_pkg::CANVAS_CENTRE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spqt_in_if.sink                        in_item,
  input  logic                           cfg_we,
  input  logic [spqt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                    cfg_wdata,
  output spqt_pkg::cfg_t                 cfg,
  output logic                           push_valid,
  output spqt_pkg::item_t                push_data,
  input  logic                           push_ready
);
  import spqt_pkg::*;

  cfg_t cfg_r;
  logic neg_ang;
  logic signed [16:0] ang17;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obj_off_x   <= '0;
      cfg_r.obj_off_y   <= '0;
      cfg_r.obj_scale_x <= UNITY_SCALE;
      cfg_r.obj_scale_y <= UNITY_SCALE;
      cfg_r.arr_off_x   <= '0;
      cfg_r.arr_off_y   <= '0;
      cfg_r.arr_scale_x <= UNITY_SCALE;
      cfg_r.arr_scale_y <= UNITY_SCALE;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OBJ_OFF_X:   cfg_r.obj_off_x   <= cfg_wdata;
        CFG_OBJ_OFF_Y:   cfg_r.obj_off_y   <= cfg_wdata;
        CFG_OBJ_SCALE_X: cfg_r.obj_scale_x <= cfg_wdata;
        CFG_OBJ_SCALE_Y: cfg_r.obj_scale_y <= cfg_wdata;
        CFG_ARR_OFF_X:   cfg_r.arr_off_x   <= cfg_wdata;
        CFG_ARR_OFF_Y:   cfg_r.arr_off_y   <= cfg_wdata;
        CFG_ARR_SCALE_X: cfg_r.arr_scale_x <= cfg_wdata;
        CFG_ARR_SCALE_Y: cfg_r.arr_scale_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // Each negative arrangement scale mirrors the part, which reverses its angle.
  assign neg_ang = cfg_r.arr_scale_x[15] ^ cfg_r.arr_scale_y[15];
  assign ang17   = 17'(in_item.angle);

  // Classify the item and precompute the top-left corner relative to the canvas.
  always_comb begin
    push_data.is_part  = in_item.mode;
    push_data.pos_x    = in_item.pos_x;
    push_data.pos_y    = in_item.pos_y;
    push_data.scale_x  = in_item.scale_x;
    push_data.scale_y  = in_item.scale_y;
    push_data.angle    = (in_item.mode && neg_ang) ? -ang17 : ang17;
    push_data.region_w = in_item.region_w;
    push_data.region_h = in_item.region_h;
    push_data.flip_x   = in_item.flip_x;
    push_data.flip_y   = in_item.flip_y;
    push_data.tl_x     = (TLW'(in_item.pos_x) - TLW'(CANVAS_CENTRE)) <<< 8;
    push_data.tl_y     = (TLW'(in_item.pos_y) - TLW'(CANVAS_CENTRE)) <<< 8;
  end

  assign push_valid    = in_item.valid;
  assign in_item.ready = push_ready;

endmodule

### src/spqt_queue.sv
module spqt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  spqt_pkg::item_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output spqt_pkg::item_t pop_data,
  input  logic            pop_ready
);
  import spqt_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### src/spqt_trig.sv
module spqt_trig #(
  parameter int ANGLE_FRAC_BITS = spqt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] angle,
  output logic               done,
  output spqt_pkg::trig_t    res
);
  import spqt_pkg::*;

  localparam int VW      = 27;
  localparam int RW      = 25;
  localparam int ZW      = 24;
  localparam int XW      = 34;
  localparam int MOD_M   = 360 << ANGLE_FRAC_BITS;
  localparam int SHIFT   = 16 - ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 * 65536;
  localparam logic [VW-1:0] M8 = VW'(MOD_M) << 8;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MOD  = 3'd1;
  localparam logic [2:0] T_PREP = 3'd2;
  localparam logic [2:0] T_ITER = 3'd3;
  localparam logic [2:0] T_FIN  = 3'd4;

  logic [2:0]            state_r;
  logic [VW-1:0]         v_r;
  logic [3:0]            j_r;
  logic [3:0]            i_r;
  logic [1:0]            q_r;
  logic                  unit_r;
  logic signed [ZW-1:0]  z_r;
  logic signed [XW-1:0]  x_r, y_r;
  logic                  done_r;
  trig_t                 res_r;

  logic [VW-1:0]         msh;
  logic [RW-1:0]         r;
  logic [1:0]            q;
  logic [RW-1:0]         qbase;
  logic signed [XW-1:0]  dx, dy, atn;
  logic signed [XW-1:0]  xr, yr;
  logic signed [15:0]    cc, ss;

  assign msh = VW'(MOD_M) << j_r;
  assign r   = RW'(v_r << SHIFT);

  // Quadrant of the reduced angle
  always_comb begin
    if (r >= RW'(3 * QUARTER)) begin
      q = 2'd3; qbase = RW'(3 * QUARTER);
    end else if (r >= RW'(2 * QUARTER)) begin
      q = 2'd2; qbase = RW'(2 * QUARTER);
    end else if (r >= RW'(QUARTER)) begin
      q = 2'd1; qbase = RW'(QUARTER);
    end else begin
      q = 2'd0; qbase = '0;
    end
  end

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign atn = XW'(atan_q16(i_r));

  // Round the Q.30 result to Q.14
  assign xr = (x_r + 34'sd32768) >>> 16;
  assign yr = (y_r + 34'sd32768) >>> 16;
  assign cc = unit_r ? TRIG_ONE : xr[15:0];
  assign ss = unit_r ? 16'sd0 : yr[15:0];

  // Done pulses for one cycle once the result register is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ((state_r == T_PREP) && (r == '0)) || (state_r == T_FIN);
    end
  end

  // Reduction modulo a full turn, then the CORDIC iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (start) begin
            v_r     <= angle[16] ? VW'(angle) + M8 : VW'(angle);
            j_r     <= 4'd8;
            state_r <= T_MOD;
          end
        end
        T_MOD: begin
          if (v_r >= msh) v_r <= v_r - msh;
          if (j_r == 4'd0) state_r <= T_PREP;
          j_r <= j_r - 1'b1;
        end
        T_PREP: begin
          q_r    <= q;
          unit_r <= (r == qbase);
          z_r    <= $signed(ZW'(r - qbase));
          x_r    <= GAIN_Q30;
          y_r    <= '0;
          i_r    <= '0;
          if (r == '0) begin
            res_r.cos_v <= TRIG_ONE;
            res_r.sin_v <= '0;
            res_r.skip  <= 1'b1;
            state_r     <= T_IDLE;
          end else if (r == qbase) begin
            state_r <= T_FIN;
          end else begin
            state_r <= T_ITER;
          end
        end
        T_ITER: begin
          if (!z_r[ZW-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - ZW'(atn);
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + ZW'(atn);
          end
          i_r <= i_r + 1'b1;
          if (i_r == 4'd15) state_r <= T_FIN;
        end
        T_FIN: begin
          case (q_r)
            2'd0:    begin res_r.cos_v <= cc;  res_r.sin_v <= ss;  end
            2'd1:    begin res_r.cos_v <= -ss; res_r.sin_v <= cc;  end
            2'd2:    begin res_r.cos_v <= -cc; res_r.sin_v <= -ss; end
            default: begin res_r.cos_v <= ss;  res_r.sin_v <= -cc; end
          endcase
          res_r.skip <= 1'b0;
          state_r    <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### src/spqt_back.sv
module spqt_back #(
  parameter int SCALE_FRAC_BITS = spqt_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  spqt_pkg::item_t    pop_data,
  output logic               pop_ready,
  input  spqt_pkg::cfg_t     cfg,
  output logic               trig_start,
  output logic signed [16:0] trig_angle,
  input  logic               trig_done,
  input  spqt_pkg::trig_t    trig_res,
  spqt_out_if.source         out_item
);
  import spqt_pkg::*;

  localparam logic [4:0] B_IDLE   = 5'd0;
  localparam logic [4:0] B_TRIG1  = 5'd1;
  localparam logic [4:0] B_TRIG2  = 5'd2;
  localparam logic [4:0] B_RECT_M = 5'd3;
  localparam logic [4:0] B_RECT_A = 5'd4;
  localparam logic [4:0] B_ARR_M  = 5'd5;
  localparam logic [4:0] B_ARR_A  = 5'd6;
  localparam logic [4:0] B_LOAD   = 5'd7;
  localparam logic [4:0] B_R1_M   = 5'd8;
  localparam logic [4:0] B_R1_A   = 5'd9;
  localparam logic [4:0] B_KS_M   = 5'd10;
  localparam logic [4:0] B_KS_A   = 5'd11;
  localparam logic [4:0] B_OS_M   = 5'd12;
  localparam logic [4:0] B_OS_A   = 5'd13;
  localparam logic [4:0] B_R2_M   = 5'd14;
  localparam logic [4:0] B_R2_A   = 5'd15;
  localparam logic [4:0] B_EMIT   = 5'd16;

  localparam int unsigned SFB = SCALE_FRAC_BITS;

  logic [4:0]           state_r;
  item_t                item_r;
  logic signed [15:0]   kpos_x_r, kpos_y_r, kscale_x_r, kscale_y_r, kangle_r;
  trig_t                t1_r, t2_r;
  logic signed [CW-1:0] tlx_r, brx_r, tly_r, bry_r, cx_r, cy_r;
  logic signed [CW-1:0] kpx_r, kpy_r, wx_r, wy_r;
  logic [1:0]           k_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;

  logic                 out_valid_r, out_last_r;
  logic [1:0]           out_corner_r;
  logic [31:0]          out_x_r, out_y_r;

  logic signed [AW-1:0] ma0, ma1, ma2, ma3;
  logic signed [BW-1:0] mb0, mb1, mb2, mb3;
  logic signed [CW-1:0] rcx, rcy;
  logic signed [AW-1:0] dx, dy;
  logic signed [15:0]   rc, rs;
  logic                 in_r2, left, top, emit_ok;
  logic signed [63:0]   ox8, oy8;

  assign in_r2 = (state_r == B_R2_M) || (state_r == B_R2_A);
  assign ox8   = 64'(cfg.obj_off_x) <<< 8;
  assign oy8   = 64'(cfg.obj_off_y) <<< 8;
  assign rcx   = in_r2 ? CW'(ox8) : cx_r;
  assign rcy   = in_r2 ? CW'(oy8) : cy_r;
  assign rc    = in_r2 ? t2_r.cos_v : t1_r.cos_v;
  assign rs    = in_r2 ? t2_r.sin_v : t1_r.sin_v;
  assign dx    = AW'(wx_r) - AW'(rcx);
  assign dy    = AW'(wy_r) - AW'(rcy);

  // Corner selection with flips: slots 0 and 3 are left, 0 and 1 are top
  assign left = (k_r == 2'd0) || (k_r == 2'd3);
  assign top  = (k_r == 2'd0) || (k_r == 2'd1);

  assign emit_ok = !out_valid_r || out_item.ready;

  // Operand selection for the four shared multipliers
  always_comb begin
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
    ma2 = '0; mb2 = '0; ma3 = '0; mb3 = '0;
    case (state_r)
      B_RECT_M: begin
        ma0 = AW'($signed({1'b0, item_r.region_w})); mb0 = item_r.scale_x;
        ma1 = AW'($signed({1'b0, item_r.region_h})); mb1 = item_r.scale_y;
        ma2 = AW'(kpos_x_r); mb2 = cfg.obj_scale_x;
        ma3 = AW'(kpos_y_r); mb3 = cfg.obj_scale_y;
      end
      B_ARR_M: begin
        ma0 = AW'(tlx_r); mb0 = cfg.arr_scale_x;
        ma1 = AW'(brx_r); mb1 = cfg.arr_scale_x;
        ma2 = AW'(tly_r); mb2 = cfg.arr_scale_y;
        ma3 = AW'(bry_r); mb3 = cfg.arr_scale_y;
      end
      B_R1_M, B_R2_M: begin
        ma0 = dx; mb0 = rc;
        ma1 = dy; mb1 = rs;
        ma2 = dx; mb2 = rs;
        ma3 = dy; mb3 = rc;
      end
      B_KS_M: begin
        ma0 = AW'(wx_r); mb0 = kscale_x_r;
        ma1 = AW'(wy_r); mb1 = kscale_y_r;
      end
      B_OS_M: begin
        ma0 = AW'(wx_r); mb0 = cfg.obj_scale_x;
        ma1 = AW'(wy_r); mb1 = cfg.obj_scale_y;
      end
      default: ;
    endcase
  end

  // Product registers
  always_ff @(posedge clk) begin
    p0_r <= ma0 * mb0;
    p1_r <= ma1 * mb1;
    p2_r <= ma2 * mb2;
    p3_r <= ma3 * mb3;
  end

  assign pop_ready  = (state_r == B_IDLE);
  assign trig_start = (state_r == B_IDLE && pop_valid && pop_data.is_part) ||
                      (state_r == B_TRIG1 && trig_done);
  assign trig_angle = (state_r == B_IDLE) ? pop_data.angle : 17'(kangle_r);

  // Output valid: set when a vertex is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_EMIT && emit_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer over one part: rectangle, quad, then each vertex in slot order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      kpos_x_r    <= '0;
      kpos_y_r    <= '0;
      kscale_x_r  <= UNITY_SCALE;
      kscale_y_r  <= UNITY_SCALE;
      kangle_r    <= '0;
      k_r         <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            item_r <= pop_data;
            if (pop_data.is_part) begin
              state_r <= B_TRIG1;
            end else begin
              kpos_x_r   <= pop_data.pos_x;
              kpos_y_r   <= pop_data.pos_y;
              kscale_x_r <= pop_data.scale_x;
              kscale_y_r <= pop_data.scale_y;
              kangle_r   <= pop_data.angle[15:0];
            end
          end
        end
        B_TRIG1: begin
          if (trig_done) begin
            t1_r    <= trig_res;
            state_r <= B_TRIG2;
          end
        end
        B_TRIG2: begin
          if (trig_done) begin
            t2_r    <= trig_res;
            state_r <= B_RECT_M;
          end
        end
        B_RECT_M: begin
          tlx_r   <= CW'(item_r.tl_x);
          tly_r   <= CW'(item_r.tl_y);
          state_r <= B_RECT_A;
        end
        B_RECT_A: begin
          brx_r   <= CW'(64'(tlx_r) + rnd_sh(64'(p0_r) <<< 8, SFB));
          bry_r   <= CW'(64'(tly_r) + rnd_sh(64'(p1_r) <<< 8, SFB));
          kpx_r   <= CW'(rnd_sh(64'(p2_r) <<< 8, SFB));
          kpy_r   <= CW'(rnd_sh(64'(p3_r) <<< 8, SFB));
          state_r <= B_ARR_M;
        end
        B_ARR_M: state_r <= B_ARR_A;
        B_ARR_A: begin
          tlx_r   <= sat40(rnd_sh(64'(p0_r), SFB) + (64'(cfg.arr_off_x) <<< 8));
          brx_r   <= sat40(rnd_sh(64'(p1_r), SFB) + (64'(cfg.arr_off_x) <<< 8));
          tly_r   <= sat40(rnd_sh(64'(p2_r), SFB) + (64'(cfg.arr_off_y) <<< 8));
          bry_r   <= sat40(rnd_sh(64'(p3_r), SFB) + (64'(cfg.arr_off_y) <<< 8));
          k_r     <= '0;
          state_r <= B_LOAD;
        end
        B_LOAD: begin
          cx_r    <= CW'(rnd_sh(64'(tlx_r) + 64'(brx_r), 1));
          cy_r    <= CW'(rnd_sh(64'(tly_r) + 64'(bry_r), 1));
          wx_r    <= (left ^ item_r.flip_x) ? tlx_r : brx_r;
          wy_r    <= (top ^ item_r.flip_y) ? tly_r : bry_r;
          state_r <= t1_r.skip ? B_KS_M : B_R1_M;
        end
        B_R1_M: state_r <= B_R1_A;
        B_R1_A: begin
          wx_r <= sat40(rnd_sh(64'(p0_r) - 64'(p1_r), TRIG_FRAC) + 64'(cx_r));
          wy_r <= sat40(rnd_sh(64'(p2_r) + 64'(p3_r), TRIG_FRAC) + 64'(cy_r));
          state_r <= B_KS_M;
        end
        B_KS_M: state_r <= B_KS_A;
        B_KS_A: begin
          wx_r    <= sat40(rnd_sh(64'(p0_r), SFB));
          wy_r    <= sat40(rnd_sh(64'(p1_r), SFB));
          state_r <= B_OS_M;
        end
        B_OS_M: state_r <= B_OS_A;
        B_OS_A: begin
          wx_r    <= sat40(rnd_sh(64'(p0_r), SFB) + ox8);
          wy_r    <= sat40(rnd_sh(64'(p1_r), SFB) + oy8);
          state_r <= t2_r.skip ? B_EMIT : B_R2_M;
        end
        B_R2_M: state_r <= B_R2_A;
        B_R2_A: begin
          wx_r <= sat40(rnd_sh(64'(p0_r) - 64'(p1_r), TRIG_FRAC) + 64'(rcx));
          wy_r <= sat40(rnd_sh(64'(p2_r) + 64'(p3_r), TRIG_FRAC) + 64'(rcy));
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (emit_ok) begin
            out_corner_r <= k_r;
            out_x_r      <= sat32(64'(wx_r) + 64'(kpx_r));
            out_y_r      <= sat32(64'(wy_r) + 64'(kpy_r));
            out_last_r   <= (k_r == 2'd3);
            k_r          <= k_r + 1'b1;
            state_r      <= (k_r == 2'd3) ? B_IDLE : B_LOAD;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_item.valid  = out_valid_r;
  assign out_item.corner = out_corner_r;
  assign out_item.vert_x = out_x_r;
  assign out_item.vert_y = out_y_r;
  assign out_item.last   = out_last_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spqt_pkg::*;

  localparam int  CANVAS    = 512;
  localparam int  SFRAC     = 12;
  localparam int  AFRAC     = 6;
  localparam int  DRAIN_CYC = 300;
  localparam int  HOLD_CYC  = 400;
  localparam longint LIM = 64'sd1 <<< 40;

  typedef enum bit {MODE_KEY = 1'b0, MODE_PART = 1'b1} mode_e;
  typedef enum logic [1:0] {
    CORNER_TL = 2'd0, CORNER_TR = 2'd1, CORNER_BR = 2'd2, CORNER_BL = 2'd3
  } corner_e;

  typedef struct {
    mode_e            mode;
    logic signed [15:0] pos_x, pos_y, scale_x, scale_y, angle;
    logic [11:0]      region_w, region_h;
    logic             flip_x, flip_y;
  } sprite_item_t;

  typedef struct {
    logic [1:0]         corner;
    logic signed [31:0] vx, vy;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  spqt_in_if  in_item ();
  spqt_out_if out_item ();

  sprite_part_quad_transform dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  sprite_item_t pending_items[$];
  vertex_t      expected_verts[$];
  sprite_item_t offered;

  // Testbench copies of the registers and the latched key transform.
  longint regs[8];
  longint key_sx, key_sy, key_ang, key_px, key_py;

  int errors = 0, parts_sent = 0, keys_sent = 0, verts_seen = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_out = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d vertices still expected", expected_verts.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Arithmetic helpers matching the fixed-point rules of the block.
  function automatic longint round_sh(input longint v, input int n);
    if (n == 0) return v;
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp40(input longint v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Sine and cosine in Q.14; returns 0 when the angle is a whole turn.
  function automatic bit sin_cos(input longint a, output longint c, output longint s);
    longint full, quarter, r, q, z, x, y, cc, ss, dx, dy;
    longint atan_tab[16];
    full = 360 * 65536;
    quarter = 90 * 65536;
    atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    r = (a * (64'sd1 <<< (16 - AFRAC))) % full;
    if (r < 0) r += full;
    if (r == 0) return 1'b0;
    q = r / quarter;
    z = r - q * quarter;
    if (z == 0) begin
      cc = 16384;
      ss = 0;
    end else begin
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      cc = round_sh(x, 16);
      ss = round_sh(y, 16);
    end
    case (q)
      0: begin c = cc;  s = ss;  end
      1: begin c = -ss; s = cc;  end
      2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
    return 1'b1;
  endfunction

  function automatic void rotate_quad(inout longint px[4], inout longint py[4],
                                      input longint a, input longint ox,
                                      input longint oy);
    longint c, s, dx, dy;
    if (!sin_cos(a, c, s)) return;
    for (int k = 0; k < 4; k++) begin
      dx = px[k] - ox;
      dy = py[k] - oy;
      px[k] = clamp40(round_sh(dx * c - dy * s, 14) + ox);
      py[k] = clamp40(round_sh(dx * s + dy * c, 14) + oy);
    end
  endfunction

  // Work out the four screen vertices of a part, or latch a key transform.
  function automatic void predict_quad(input sprite_item_t it);
    longint tlx, tly, brx, bry, cx, cy, ox, oy, ang, t, x, y;
    longint qx[4], qy[4];
    vertex_t v;
    if (it.mode == MODE_KEY) begin
      key_px = it.pos_x; key_py = it.pos_y;
      key_sx = it.scale_x; key_sy = it.scale_y;
      key_ang = it.angle;
      return;
    end
    tlx = (longint'(it.pos_x) - CANVAS) * 256;
    tly = (longint'(it.pos_y) - CANVAS) * 256;
    brx = tlx + round_sh(longint'(it.region_w) * it.scale_x * 256, SFRAC);
    bry = tly + round_sh(longint'(it.region_h) * it.scale_y * 256, SFRAC);
    tlx = clamp40(round_sh(tlx * regs[CFG_ARR_SCALE_X], SFRAC) + regs[CFG_ARR_OFF_X] * 256);
    brx = clamp40(round_sh(brx * regs[CFG_ARR_SCALE_X], SFRAC) + regs[CFG_ARR_OFF_X] * 256);
    tly = clamp40(round_sh(tly * regs[CFG_ARR_SCALE_Y], SFRAC) + regs[CFG_ARR_OFF_Y] * 256);
    bry = clamp40(round_sh(bry * regs[CFG_ARR_SCALE_Y], SFRAC) + regs[CFG_ARR_OFF_Y] * 256);
    qx = '{tlx, brx, brx, tlx};
    qy = '{tly, tly, bry, bry};
    cx = round_sh(tlx + brx, 1);
    cy = round_sh(tly + bry, 1);
    // Horizontal flip swaps left and right; vertical flip swaps top and bottom.
    if (it.flip_x) begin
      t = qx[0]; qx[0] = qx[1]; qx[1] = t; t = qy[0]; qy[0] = qy[1]; qy[1] = t;
      t = qx[2]; qx[2] = qx[3]; qx[3] = t; t = qy[2]; qy[2] = qy[3]; qy[3] = t;
    end
    if (it.flip_y) begin
      t = qx[0]; qx[0] = qx[3]; qx[3] = t; t = qy[0]; qy[0] = qy[3]; qy[3] = t;
      t = qx[1]; qx[1] = qx[2]; qx[2] = t; t = qy[1]; qy[1] = qy[2]; qy[2] = t;
    end
    ang = it.angle;
    if (regs[CFG_ARR_SCALE_X] < 0) ang = -ang;
    if (regs[CFG_ARR_SCALE_Y] < 0) ang = -ang;
    rotate_quad(qx, qy, ang, cx, cy);
    ox = regs[CFG_OBJ_OFF_X] * 256;
    oy = regs[CFG_OBJ_OFF_Y] * 256;
    for (int k = 0; k < 4; k++) begin
      x = clamp40(round_sh(qx[k] * key_sx, SFRAC));
      y = clamp40(round_sh(qy[k] * key_sy, SFRAC));
      qx[k] = clamp40(round_sh(x * regs[CFG_OBJ_SCALE_X], SFRAC) + ox);
      qy[k] = clamp40(round_sh(y * regs[CFG_OBJ_SCALE_Y], SFRAC) + oy);
    end
    rotate_quad(qx, qy, key_ang, ox, oy);
    for (int k = 0; k < 4; k++) begin
      v.corner = k[1:0];
      v.vx = clamp32(qx[k] + round_sh(key_px * regs[CFG_OBJ_SCALE_X] * 256, SFRAC));
      v.vy = clamp32(qy[k] + round_sh(key_py * regs[CFG_OBJ_SCALE_Y] * 256, SFRAC));
      v.last = (k == CORNER_BL);
      expected_verts.push_back(v);
    end
  endfunction

  // Driver: offers queued items, idling now and then, and predicts on accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_item.valid <= 1'b0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        predict_quad(offered);
        if (offered.mode == MODE_PART) parts_sent++;
        else keys_sent++;
      end
      if (!in_item.valid || in_item.ready) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
          offered = pending_items.pop_front();
          in_item.valid    <= 1'b1;
          in_item.mode     <= offered.mode;
          in_item.pos_x    <= offered.pos_x;
          in_item.pos_y    <= offered.pos_y;
          in_item.scale_x  <= offered.scale_x;
          in_item.scale_y  <= offered.scale_y;
          in_item.angle    <= offered.angle;
          in_item.region_w <= offered.region_w;
          in_item.region_h <= offered.region_h;
          in_item.flip_x   <= offered.flip_x;
          in_item.flip_y   <= offered.flip_y;
        end else begin
          in_item.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once requested.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYC;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    hold_out <= (hold_left > 1);
  end

  // Monitor: random back-pressure and field-by-field compare.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      out_item.ready <= 1'b0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        verts_seen++;
        if (expected_verts.size() == 0) begin
          report($sformatf("unexpected vertex corner %0d", out_item.corner));
        end else begin
          e = expected_verts.pop_front();
          if (out_item.corner !== e.corner)
            report($sformatf("corner %0d, want %0d", out_item.corner, e.corner));
          if (out_item.vert_x !== e.vx)
            report($sformatf("corner %0d vert_x %0d, want %0d", e.corner,
                             out_item.vert_x, e.vx));
          if (out_item.vert_y !== e.vy)
            report($sformatf("corner %0d vert_y %0d, want %0d", e.corner,
                             out_item.vert_y, e.vy));
          if (out_item.last !== e.last)
            report($sformatf("corner %0d last %0b, want %0b", e.corner,
                             out_item.last, e.last));
        end
      end
      out_item.ready <= hold_out ? 1'b0 : (quiet || $urandom_range(99) >= 14);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    regs[idx] = longint'($signed(val));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(CFG_OBJ_OFF_X, v0);
    write_reg(CFG_OBJ_OFF_Y, v1);
    write_reg(CFG_OBJ_SCALE_X, v2);
    write_reg(CFG_OBJ_SCALE_Y, v3);
    write_reg(CFG_ARR_OFF_X, v4);
    write_reg(CFG_ARR_OFF_Y, v5);
    write_reg(CFG_ARR_SCALE_X, v6);
    write_reg(CFG_ARR_SCALE_Y, v7);
  endtask

  // Wait until every item is taken and every vertex has come back.
  task automatic wait_drained(input int extra);
    while (pending_items.size() > 0 || in_item.valid || expected_verts.size() > 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic sprite_item_t make_item(input mode_e m, input int px, py, sx, sy,
                                             input int ang, rw, rh, input bit fx, fy);
    sprite_item_t it;
    it.mode = m; it.pos_x = px; it.pos_y = py; it.scale_x = sx; it.scale_y = sy;
    it.angle = ang; it.region_w = rw; it.region_h = rh; it.flip_x = fx; it.flip_y = fy;
    return it;
  endfunction

  function automatic logic [15:0] near(input int centre, input int span);
    return centre + $urandom_range(2 * span) - span;
  endfunction

  // Random item: mostly parts of moderate size, some keys, some raw extremes.
  function automatic sprite_item_t random_item();
    sprite_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.mode     = ($urandom_range(99) < 20) ? MODE_KEY : MODE_PART;
    it.flip_x   = $urandom_range(1);
    it.flip_y   = $urandom_range(1);
    if (pick < 20) begin
      it.pos_x = $urandom; it.pos_y = $urandom; it.scale_x = $urandom;
      it.scale_y = $urandom; it.angle = $urandom;
      it.region_w = $urandom; it.region_h = $urandom;
    end else begin
      it.pos_x    = near(it.mode == MODE_KEY ? 0 : CANVAS, 400);
      it.pos_y    = near(it.mode == MODE_KEY ? 0 : CANVAS, 400);
      it.scale_x  = near(4096, 6000);
      it.scale_y  = near(4096, 6000);
      it.angle    = (pick < 30) ? 5760 * $urandom_range(7) - 11520 : near(0, 23040);
      it.region_w = $urandom_range(256);
      it.region_h = $urandom_range(256);
    end
    return it;
  endfunction

  initial begin
    in_item.valid = 1'b0; in_item.mode = 1'b0; in_item.pos_x = '0; in_item.pos_y = '0;
    in_item.scale_x = '0; in_item.scale_y = '0; in_item.angle = '0;
    in_item.region_w = '0; in_item.region_h = '0; in_item.flip_x = 1'b0;
    in_item.flip_y = 1'b0; out_item.ready = 1'b0;
    regs = '{0, 0, 4096, 4096, 0, 0, 4096, 4096};
    key_sx = 4096; key_sy = 4096; key_ang = 0; key_px = 0; key_py = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: part before any key, flips, exact quarter turns, extremes.
    pending_items.push_back(make_item(MODE_PART, 600, 450, 4096, 4096, 0, 32, 16, 0, 0));
    pending_items.push_back(make_item(MODE_PART, 600, 450, 4096, 4096, 1920, 32, 16, 1, 0));
    pending_items.push_back(make_item(MODE_PART, 600, 450, 4096, 4096, 5760, 32, 16, 0, 1));
    pending_items.push_back(make_item(MODE_PART, 600, 450, 8192, 2048, 23040, 32, 16, 1, 1));
    pending_items.push_back(make_item(MODE_PART, 512, 512, 4096, 4096, 11520, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_PART, -32768, 32767, -32768, 32767, -32768,
                                      4095, 4095, 1, 0));
    pending_items.push_back(make_item(MODE_PART, 32767, -32768, 32767, -32768, 32767,
                                      4095, 0, 0, 1));
    pending_items.push_back(make_item(MODE_KEY, 100, -50, 6144, 2048, 2880, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_PART, 520, 500, 4096, 4096, -960, 64, 48, 0, 0));
    pending_items.push_back(make_item(MODE_KEY, 0, 0, 4096, 4096, -23040, 4095, 4095, 1, 1));
    pending_items.push_back(make_item(MODE_PART, 520, 500, 4096, 4096, 17280, 64, 48, 1, 1));
    pending_items.push_back(make_item(MODE_KEY, 32767, -32768, 32767, -32768, 32767,
                                      0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_PART, 512, 512, 4096, 4096, 640, 10, 10, 0, 0));
    pending_items.push_back(make_item(MODE_KEY, -32768, 32767, -32768, 0, -32768,
                                      0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_PART, 0, 1023, -4096, 4096, 5760, 100, 50, 1, 0));
    pending_items.push_back(make_item(MODE_KEY, 10, 20, 4096, 4096, 0, 0, 0, 0, 0));
    wait_drained(DRAIN_CYC);

    // Register extremes, with negative arrangement scales flipping the angle.
    write_all(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
              16'h8000, 16'h7FFF);
    for (int i = 0; i < 20; i++) pending_items.push_back(random_item());
    wait_drained(DRAIN_CYC);

    write_all(16'd40, -16'sd25, 16'd4096, 16'd4096, 16'd0, 16'd0, -16'sd4096, 16'd4096);
    for (int i = 0; i < 40; i++) pending_items.push_back(random_item());
    wait_drained(DRAIN_CYC);

    // Main random phase: a long receiver hold-off and a sender pause halfway.
    write_all(near(0, 300), near(0, 300), near(4096, 3000), near(4096, 3000),
              near(0, 200), near(0, 200), near(0, 6000), near(0, 6000));
    hold_go = 1'b1;
    for (int i = 0; i < 150; i++) pending_items.push_back(random_item());
    wait_drained(0);
    for (int i = 0; i < 150; i++) pending_items.push_back(random_item());
    wait_drained(DRAIN_CYC);

    // Back to reset values with no idling on either side.
    write_all(16'd0, 16'd0, 16'd4096, 16'd4096, 16'd0, 16'd0, 16'd4096, 16'd4096);
    quiet = 1'b1;
    for (int i = 0; i < 60; i++) pending_items.push_back(random_item());
    wait_drained(DRAIN_CYC);
    quiet = 1'b0;

    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
    for (int i = 0; i < 80; i++) pending_items.push_back(random_item());
    wait_drained(DRAIN_CYC);

    $display("Covered %0d parts and %0d key loads, %0d vertices checked,", parts_sent,
             keys_sent, verts_seen);
    $display("over six register settings including both extremes; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
